// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the RGB triple text parser.
// No dependencies; the assertions compile out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check that prop holds at every rising clock edge outside reset.
`define RTP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that cond is never true at a rising clock edge outside reset.
`define RTP_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RTP_ASSERT(label, clk, rst_n, prop, msg)
`define RTP_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/rtp_pkg.sv =====
// Types and constants of the RGB triple text parser.
// No dependencies; used by the parse step, the output register and the top level.
package rtp_pkg;

    // parse phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SEP  = 2'd1;
    localparam logic [1:0] PH_NUM  = 2'd2;

    // component codes
    localparam logic [1:0] COMP_RED   = 2'd0;
    localparam logic [1:0] COMP_GREEN = 2'd1;
    localparam logic [1:0] COMP_BLUE  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_NO_COMMA = 2'd2;

    // characters
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_COMMA = 8'd44;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    localparam logic [8:0] ACC_SAT  = 9'd256;
    localparam logic [8:0] VAL_MAX  = 9'd255;
    localparam logic [7:0] CNT_MAX  = 8'd255;

    typedef struct packed {
        logic [1:0] comp;
        logic [1:0] phase;
        logic [8:0] acc;
        logic       neg;
        logic [7:0] red_held;
        logic [7:0] green_held;
        logic [7:0] cnt;
    } state_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] consumed;
    } result_t;

endpackage

// ===== hw/rtl/rtp_if.sv =====
// Valid/ready channel interfaces of the RGB triple text parser.
// No dependencies.
interface rtp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       start_req;

    modport source (output valid, output ch, output start_req, input ready);
    modport sink (input valid, input ch, input start_req, output ready);
endinterface

interface rtp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] consumed;

    modport source (output valid, output status, output red, output green,
                    output blue, output consumed, input ready);
    modport sink (input valid, input status, input red, input green,
                  input blue, input consumed, output ready);
endinterface

// ===== hw/rtl/rtp_step.sv =====
// Combinational parse step: next parser state and optional result for one character.
// Depends on rtp_pkg.
module rtp_step
    import rtp_pkg::*;
(
    input  state_t     cur,
    input  logic [7:0] ch,
    input  logic       start_req,
    output state_t     nxt,
    output logic       fire,
    output result_t    res
);

    state_t      s;
    logic        is_digit;
    logic [7:0]  ch_off;
    logic [3:0]  digit;
    logic [11:0] prod;
    logic [8:0]  acc_add;
    logic [7:0]  cnt_inc;
    logic        end_comp;

    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign ch_off   = ch - CH_ZERO;
    assign digit    = ch_off[3:0];

    always_comb
    begin
        s = cur;
        if (start_req)
        begin
            s.comp       = COMP_RED;
            s.phase      = PH_SEP;
            s.acc        = '0;
            s.neg        = 1'b0;
            s.red_held   = '0;
            s.green_held = '0;
            s.cnt        = '0;
        end

        // acc * 10 + digit, saturate at 256
        prod    = ({3'b000, s.acc} << 3) + ({3'b000, s.acc} << 1) + {8'd0, digit};
        acc_add = (prod > {3'b000, ACC_SAT}) ? ACC_SAT : prod[8:0];
        cnt_inc = (s.cnt == CNT_MAX) ? s.cnt : s.cnt + 8'd1;

        nxt      = s;
        fire     = 1'b0;
        res      = '0;
        end_comp = 1'b0;

        case (s.phase)
            PH_SEP:
            begin
                if (ch inside {CH_SPACE, CH_TAB})
                begin
                    nxt.cnt = cnt_inc;
                end
                else if (ch == CH_MINUS)
                begin
                    nxt.neg   = 1'b1;
                    nxt.cnt   = cnt_inc;
                    nxt.phase = PH_NUM;
                end
                else if (is_digit)
                begin
                    nxt.acc   = acc_add;
                    nxt.cnt   = cnt_inc;
                    nxt.phase = PH_NUM;
                end
                else
                begin
                    end_comp = 1'b1;
                end
            end
            PH_NUM:
            begin
                if (is_digit)
                begin
                    nxt.acc = acc_add;
                    nxt.cnt = cnt_inc;
                end
                else
                begin
                    end_comp = 1'b1;
                end
            end
            default:
            begin
                end_comp = 1'b0;
            end
        endcase

        if (end_comp)
        begin
            if ((s.neg && (s.acc != '0)) || (s.acc > VAL_MAX))
            begin
                nxt.phase  = PH_IDLE;
                fire       = 1'b1;
                res.status = ST_RANGE;
            end
            else if (s.comp == COMP_RED || s.comp == COMP_GREEN)
            begin
                if (ch != CH_COMMA)
                begin
                    nxt.phase  = PH_IDLE;
                    fire       = 1'b1;
                    res.status = ST_NO_COMMA;
                end
                else
                begin
                    if (s.comp == COMP_RED)
                    begin
                        nxt.red_held = s.acc[7:0];
                    end
                    else
                    begin
                        nxt.green_held = s.acc[7:0];
                    end
                    nxt.cnt   = cnt_inc;
                    nxt.comp  = s.comp + 2'd1;
                    nxt.acc   = '0;
                    nxt.neg   = 1'b0;
                    nxt.phase = PH_SEP;
                end
            end
            else
            begin
                // blue: terminator is not consumed
                nxt.phase    = PH_IDLE;
                fire         = 1'b1;
                res.status   = ST_OK;
                res.red      = s.red_held;
                res.green    = s.green_held;
                res.blue     = s.acc[7:0];
                res.consumed = s.cnt;
            end
        end
    end

endmodule

// ===== hw/rtl/rtp_out_reg.sv =====
// Output register of the RGB triple text parser: holds one result until taken.
// Depends on rtp_pkg and the rtp_out_if interface.
module rtp_out_reg
    import rtp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  result_t          res,
    output logic             free,
    rtp_out_if.source        results
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // free when empty or the held result leaves this cycle
    assign free       = !valid_reg || results.ready;
    assign valid_next = load || (valid_reg && !results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign results.valid    = valid_reg;
    assign results.status   = res_reg.status;
    assign results.red      = res_reg.red;
    assign results.green    = res_reg.green;
    assign results.blue     = res_reg.blue;
    assign results.consumed = res_reg.consumed;

endmodule

// ===== hw/rtl/rgb_triple_text_parser.sv =====
// Top level of the RGB triple text parser: parser state, parse step, output register.
// Depends on rtp_pkg, rtp_if, rtp_step, rtp_out_reg and assert_macros.svh.
//
//   channel   direction  payload                                  transaction
//   chars     in         ch[7:0], start_req                       one text character
//   results   out        status[1:0], red, green, blue, consumed  one parsed triple
//
// Each character is parsed at the edge where it is accepted,
// updating the parser state and, when it ends a triple, loading the output register.
// A result appears on results in the cycle after the character that caused it.
// chars.ready drops only while a result sits in the output register and results.ready
// is low; a full register stalls the input, nothing else does.
// rst_n clears the parser to idle: characters are ignored until one carries start_req.
`include "assert_macros.svh"

module rgb_triple_text_parser
    import rtp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rtp_in_if.sink      chars,
    rtp_out_if.source   results
);

    state_t  state_reg;
    state_t  state_next;
    logic    fire;
    result_t res;
    logic    free;
    logic    in_acc;

    // accept whenever the output register can take a result
    assign chars.ready = free;
    assign in_acc      = chars.valid && free;

    rtp_step u_step (
        .cur       (state_reg),
        .ch        (chars.ch),
        .start_req (chars.start_req),
        .nxt       (state_next),
        .fire      (fire),
        .res       (res)
    );

    // advance the parser state only on an accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.comp       <= COMP_RED;
            state_reg.phase      <= PH_IDLE;
            state_reg.acc        <= '0;
            state_reg.neg        <= 1'b0;
            state_reg.red_held   <= '0;
            state_reg.green_held <= '0;
            state_reg.cnt        <= '0;
        end
        else if (in_acc)
        begin
            state_reg <= state_next;
        end
    end

    rtp_out_reg u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (in_acc && fire),
        .res     (res),
        .free    (free),
        .results (results)
    );

    // a finished or failed triple leaves the parser idle
    `RTP_ASSERT(a_idle_after_result, clk, rst_n, (in_acc && fire) |=> (state_reg.phase == PH_IDLE), "parser not idle after result")
    // accumulator saturates at 256
    `RTP_ASSERT_NEVER(a_acc_sat, clk, rst_n, state_reg.acc > ACC_SAT, "accumulator beyond saturation")
    // count only grows inside a triple
    `RTP_ASSERT(a_cnt_mono, clk, rst_n, (in_acc && !chars.start_req) |=> (state_reg.cnt >= $past(state_reg.cnt)), "character count decreased")
    // error results carry zero fields
    `RTP_ASSERT(a_err_zero, clk, rst_n, (results.valid && results.status != ST_OK) |-> (results.red == 8'd0 && results.green == 8'd0 && results.blue == 8'd0 && results.consumed == 8'd0), "error result with nonzero fields")

endmodule
